### hdl/pct_pkg.sv
// ---------------------------------------------------------------------------
// pct_pkg
// shared types and constants of the pausable countdown timer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

   localparam int unsigned TIME_WIDTH = 32;

   // five minutes in milliseconds
   localparam logic [TIME_WIDTH-1:0] DEFAULT_RELOAD_MS = TIME_WIDTH'(5 * 60 * 1000);

   typedef enum logic [2:0] {
      ACT_TICK         = 3'd0,
      ACT_START_LEN    = 3'd1,
      ACT_RESTART      = 3'd2,
      ACT_PAUSE        = 3'd3,
      ACT_RESUME       = 3'd4,
      ACT_RESUME_LEN   = 3'd5,
      ACT_CHECK        = 3'd6,
      ACT_ADD          = 3'd7
   } action_type;

endpackage

`default_nettype wire

### hdl/pausable_countdown_timer.sv
// ---------------------------------------------------------------------------
// pausable_countdown_timer
// millisecond countdown that can be paused, resumed, restarted and extended
// ---------------------------------------------------------------------------
// usage
//   req channel: one item per action (tick, start, restart, pause, resume,
//   resume-or-start, check, add) with amount and restart_flag
//   rsp channel: exactly one item per request, in order, carrying fired,
//   remaining time and pause flag after the action
//   path: an accepted request is held in the input register, and its
//   response in the result register
//   throughput: one item per cycle when the receiver does not stall; the
//   timer state is updated by one compare, one decrement or one saturating 32-bit add
//   reset: remaining time zero (expired), running, reload length five
//   minutes; both stages empty
//   receiver stall: the result register holds; a new item is still taken
//   into the empty input register, and req_stall rises only when both
//   registers are full and rsp_stall is high
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pausable_countdown_timer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output      logic                             req_stall,
   input  wire logic [2:0]                       req_action,
   input  wire logic [pct_pkg::TIME_WIDTH-1:0]   req_amount,
   input  wire logic                             req_restart_flag,
   // response channel
   output      logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   output      logic                             rsp_fired,
   output      logic [pct_pkg::TIME_WIDTH-1:0]   rsp_remaining,
   output      logic                             rsp_paused
);

   import pct_pkg::*;

   // input register
   logic                   in_valid_ff;
   action_type             in_action_ff;
   logic [TIME_WIDTH-1:0]  in_amount_ff;
   logic                   in_flag_ff;

   // timer state
   logic [TIME_WIDTH-1:0]  time_left_ff, time_left_in;
   logic                   hold_ff, hold_in;
   logic [TIME_WIDTH-1:0]  reload_ff, reload_in;

   // result register
   logic                   out_valid_ff;
   logic                   out_fired_ff, out_fired_in;
   logic [TIME_WIDTH-1:0]  out_remaining_ff;
   logic                   out_paused_ff;

   logic                   advance;
   logic                   load_input;
   logic                   add_hold;
   logic [TIME_WIDTH:0]    add_sum;
   logic [TIME_WIDTH-1:0]  add_sat;
   logic                   left_zero;

   // the input stage moves on when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign load_input = !req_stall;

   assign left_zero  = (time_left_ff == '0);

   // add: pause takes effect only on a running, unexpired timer
   assign add_hold   = hold_ff || !left_zero;
   assign add_sum    = {1'b0, time_left_ff} + {1'b0, in_amount_ff};
   assign add_sat    = add_sum[TIME_WIDTH] ? '1 : add_sum[TIME_WIDTH-1:0];

   // next timer state and reported expiry
   always_comb begin
      time_left_in = time_left_ff;
      hold_in      = hold_ff;
      reload_in    = reload_ff;
      out_fired_in = 1'b0;
      unique case (in_action_ff)
         ACT_TICK: begin
            if (!hold_ff && !left_zero) begin
               time_left_in = time_left_ff - 1'b1;
            end
         end
         ACT_START_LEN: begin
            reload_in    = in_amount_ff;
            time_left_in = in_amount_ff;
            hold_in      = 1'b0;
         end
         ACT_RESTART: begin
            time_left_in = reload_ff;
            hold_in      = 1'b0;
         end
         ACT_PAUSE: begin
            hold_in = add_hold;
         end
         ACT_RESUME: begin
            hold_in = 1'b0;
            if (!hold_ff) begin
               time_left_in = reload_ff;
            end
         end
         ACT_RESUME_LEN: begin
            hold_in = 1'b0;
            if (!hold_ff) begin
               reload_in    = in_amount_ff;
               time_left_in = in_amount_ff;
            end
         end
         ACT_CHECK: begin
            if (left_zero && in_flag_ff) begin
               time_left_in = reload_ff;
               hold_in      = 1'b0;
            end
         end
         ACT_ADD: begin
            // pause, extend when paused, then optional resume (restart from reload if expired)
            hold_in = add_hold;
            if (add_hold) begin
               time_left_in = add_sat;
            end
            if (in_flag_ff) begin
               hold_in = 1'b0;
               if (!add_hold) begin
                  time_left_in = reload_ff;
               end
            end
         end
      endcase
      // check reports expiry before its own restart, all others after
      if (in_action_ff == ACT_CHECK) begin
         out_fired_in = left_zero;
      end else begin
         out_fired_in = (time_left_in == '0);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         time_left_ff <= '0;
         hold_ff      <= 1'b0;
         reload_ff    <= DEFAULT_RELOAD_MS;
      end else begin
         if (load_input) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            time_left_ff <= time_left_in;
            hold_ff      <= hold_in;
            reload_ff    <= reload_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load_input) begin
         in_action_ff <= action_type'(req_action);
         in_amount_ff <= req_amount;
         in_flag_ff   <= req_restart_flag;
      end
      if (advance) begin
         out_fired_ff     <= out_fired_in;
         out_remaining_ff <= time_left_in;
         out_paused_ff    <= hold_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_fired     = out_fired_ff;
   assign rsp_remaining = out_remaining_ff;
   assign rsp_paused    = out_paused_ff;

   // a paused timer always has time left
   a_hold_not_expired: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> (time_left_ff != '0))
      else $error("timer paused with zero remaining time");

   // the input side stalls only when both stages are full and the receiver stalls
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   // a tick on a running, unexpired timer takes exactly one millisecond off
   a_tick_decrement: assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff == ACT_TICK && !hold_ff && !left_zero)
      |=> (time_left_ff == $past(time_left_ff) - 1'b1))
      else $error("tick did not decrement remaining time");

endmodule

`default_nettype wire
